// ----- design/clopd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clopd_pkg: shared definitions for the coin line optimal pick block
// Sizes, the controller states, the command and status bundles and the span table address.
// ----------------------------------------------------------------------------
package clopd_pkg;

  localparam int unsigned MaxCoins = 64;
  localparam int unsigned IdxW     = (MaxCoins > 1) ? $clog2(MaxCoins) : 1;
  localparam int unsigned CntW     = $clog2(MaxCoins + 1);
  localparam int unsigned TabDepth = MaxCoins * MaxCoins;
  localparam int unsigned TabAw    = (TabDepth > 1) ? $clog2(TabDepth) : 1;
  localparam int unsigned CoinW    = 16;
  localparam int unsigned TotalW   = 22;
  localparam int unsigned SumW     = TotalW + 1;
  localparam logic [TotalW-1:0] TotalMax = {TotalW{1'b1}};

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RD_AB,
    ST_RD_C,
    ST_FLUSH,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic store_coin;   // write the incoming coin into the row
    logic start;        // set up the loop counters for a new solve
    logic issue_ab;     // read both coins, one outer neighbour and the shared middle neighbour
    logic issue_c;      // read the remaining neighbour, capture the rest
    logic write_prev;   // finish and write the entry held in the save regs
    logic out_load;     // move the final value to the output register
  } cmd_t;

  typedef struct packed {
    logic last_entry;   // the current entry is the whole row
    logic out_free;     // output register can take a new item
  } status_t;

  // Flat address of span (i,j).
  function automatic logic [TabAw-1:0] tab_addr(input logic [IdxW-1:0] i,
                                               input logic [IdxW-1:0] j);
    logic [TabAw-1:0] row;
    row = TabAw'(i) * TabAw'(MaxCoins);
    return TabAw'(row + TabAw'(j));
  endfunction

endpackage
`default_nettype wire

// ----- design/clopd_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clopd_ctrl: sequencer for the coin line optimal pick block
// Loads the row, then steps each span through two read phases.
// ----------------------------------------------------------------------------
module clopd_ctrl (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     in_valid_i,
  input  wire                     last_coin_i,
  output logic                    in_ready_o,
  input  clopd_pkg::status_t      status_i,
  output clopd_pkg::cmd_t         cmd_o
);

  clopd_pkg::state_e state_q, state_d;
  logic              pend_q, pend_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= clopd_pkg::ST_LOAD;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    pend_d     = pend_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      clopd_pkg::ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.store_coin = 1'b1;
          if (last_coin_i) begin
            cmd_o.start = 1'b1;
            pend_d      = 1'b0;
            state_d     = clopd_pkg::ST_RD_AB;
          end
        end
      end
      clopd_pkg::ST_RD_AB: begin
        // The previous span finishes while this one starts reading.
        cmd_o.issue_ab   = 1'b1;
        cmd_o.write_prev = pend_q;
        state_d          = clopd_pkg::ST_RD_C;
      end
      clopd_pkg::ST_RD_C: begin
        cmd_o.issue_c = 1'b1;
        pend_d        = 1'b1;
        state_d       = status_i.last_entry ? clopd_pkg::ST_FLUSH
                                            : clopd_pkg::ST_RD_AB;
      end
      clopd_pkg::ST_FLUSH: begin
        cmd_o.write_prev = 1'b1;
        pend_d           = 1'b0;
        state_d          = clopd_pkg::ST_DONE;
      end
      clopd_pkg::ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = clopd_pkg::ST_LOAD;
        end
      end
      default: state_d = clopd_pkg::ST_LOAD;
    endcase
  end

endmodule
`default_nettype wire

// ----- design/clopd_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clopd_datapath: storage and arithmetic for the coin line optimal pick block
// Coin store, span table, loop counters, span evaluation and output register.
// ----------------------------------------------------------------------------
module clopd_datapath (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire  [clopd_pkg::CoinW-1:0]        coin_value_i,
  input  clopd_pkg::cmd_t                    cmd_i,
  output clopd_pkg::status_t                 status_o,
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  output logic [clopd_pkg::TotalW-1:0]       best_total_o
);

  localparam int unsigned IdxW   = clopd_pkg::IdxW;
  localparam int unsigned CntW   = clopd_pkg::CntW;
  localparam int unsigned TabAw  = clopd_pkg::TabAw;
  localparam int unsigned CoinW  = clopd_pkg::CoinW;
  localparam int unsigned TotalW = clopd_pkg::TotalW;
  localparam int unsigned SumW   = clopd_pkg::SumW;

  logic [CoinW-1:0]  coin_mem [clopd_pkg::MaxCoins];
  logic [TotalW-1:0] tab_mem  [clopd_pkg::TabDepth];

  logic [CntW-1:0]   count_q;
  logic [IdxW-1:0]   gap_q, i_q, j_q;
  logic [CoinW-1:0]  coin_i_q, coin_j_q;
  logic [TotalW-1:0] rd0_q, rd1_q;

  // Save registers for the span that is completed in the following phase.
  logic [CoinW-1:0]  sv_ci_q, sv_cj_q;
  logic [TotalW-1:0] sv_a_q, sv_b_q;
  logic              sv_deep_q;
  logic [TabAw-1:0]  sv_addr_q;

  logic [TotalW-1:0] final_q;
  logic              out_valid_q;
  logic [TotalW-1:0] best_total_q;

  logic              row_end, deep;
  logic [TotalW-1:0] nb_a, nb_b, nb_c, min_l, min_r, span_val;
  logic [SumW-1:0]   take_l, take_r, take_max;

  assign row_end = (CntW'(j_q) + CntW'(1)) == count_q;
  assign deep    = gap_q > IdxW'(1);
  assign status_o.last_entry = row_end && ((CntW'(gap_q) + CntW'(1)) == count_q);
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  // Coin store, one write port and two registered read ports.
  always_ff @(posedge clk_i) begin
    if (cmd_i.store_coin && (count_q < CntW'(clopd_pkg::MaxCoins))) begin
      coin_mem[count_q[IdxW-1:0]] <= coin_value_i;
    end
    if (cmd_i.issue_ab) begin
      coin_i_q <= coin_mem[i_q];
      coin_j_q <= coin_mem[j_q];
    end
  end

  // Span table, one write port and two registered read ports.
  always_ff @(posedge clk_i) begin
    if (cmd_i.write_prev) begin
      tab_mem[sv_addr_q] <= span_val;
    end
    if (cmd_i.issue_ab) begin
      rd0_q <= tab_mem[clopd_pkg::tab_addr(i_q + IdxW'(2), j_q)];
      rd1_q <= tab_mem[clopd_pkg::tab_addr(i_q + IdxW'(1), j_q - IdxW'(1))];
    end else if (cmd_i.issue_c) begin
      rd0_q <= tab_mem[clopd_pkg::tab_addr(i_q, j_q - IdxW'(2))];
    end
  end

  // Capture the first read phase and the span position, the final total and the output total.
  always_ff @(posedge clk_i) begin
    if (cmd_i.issue_c) begin
      sv_ci_q   <= coin_i_q;
      sv_cj_q   <= coin_j_q;
      sv_a_q    <= rd0_q;
      sv_b_q    <= rd1_q;
      sv_deep_q <= deep;
      sv_addr_q <= clopd_pkg::tab_addr(i_q, j_q);
    end
    if (cmd_i.write_prev) begin
      final_q <= span_val;
    end
    if (cmd_i.out_load) begin
      best_total_q <= final_q;
    end
  end

  // Neighbours count as zero on spans of one or two coins.
  always_comb begin
    nb_a     = sv_deep_q ? sv_a_q : '0;
    nb_b     = sv_deep_q ? sv_b_q : '0;
    nb_c     = sv_deep_q ? rd0_q  : '0;
    min_l    = (nb_a < nb_b) ? nb_a : nb_b;
    min_r    = (nb_b < nb_c) ? nb_b : nb_c;
    take_l   = SumW'(sv_ci_q) + SumW'(min_l);
    take_r   = SumW'(sv_cj_q) + SumW'(min_r);
    take_max = (take_l > take_r) ? take_l : take_r;
    span_val = (take_max > SumW'(clopd_pkg::TotalMax)) ? clopd_pkg::TotalMax
                                                        : take_max[TotalW-1:0];
  end

  // Coin count and the diagonal walk.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      gap_q   <= '0;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      if (cmd_i.out_load) begin
        count_q <= '0;
      end else if (cmd_i.store_coin && (count_q < CntW'(clopd_pkg::MaxCoins))) begin
        count_q <= count_q + CntW'(1);
      end
      if (cmd_i.start) begin
        gap_q <= '0;
        i_q   <= '0;
        j_q   <= '0;
      end else if (cmd_i.issue_c) begin
        if (row_end) begin
          gap_q <= gap_q + IdxW'(1);
          i_q   <= '0;
          j_q   <= gap_q + IdxW'(1);
        end else begin
          i_q <= i_q + IdxW'(1);
          j_q <= j_q + IdxW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign best_total_o = best_total_q;

endmodule
`default_nettype wire

// ----- design/coin_line_optimal_pick_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// coin_line_optimal_pick_dp: optimal first-player total for a row of coins
// Stores a row of coins and solves the two-ended pick game by interval
// dynamic programming over a span table, diagonal by diagonal.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake               Payload
//   -------   ---------------------   ----------------------------------
//   input     in_valid_i/in_ready_o   coin_value_i (16 b), last_coin_i
//   output    out_valid_o/out_ready_i best_total_o (22 b)
//
// Each coin item is taken in the cycle that it is offered while loading.
// The item marked as the last coin starts the solve: every span of the
// row runs through two read phases, as its three neighbours share the two
// read ports of the span table. After a flush phase the total is registered
// once the output register is free, and the input is ready again in the
// cycle after that. No input item is taken during the solve.
// Reset clears the controller and the coin count; both stores need no
// clearing, since every entry is written before it is read within a row.
// The finished total sits in an output register, so the next row may load
// while the result still waits; a row end waits for that register to free.
//
module coin_line_optimal_pick_dp (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               in_valid_i,
  output logic                              in_ready_o,
  input  wire  [clopd_pkg::CoinW-1:0]       coin_value_i,
  input  wire                               last_coin_i,
  output logic                              out_valid_o,
  input  wire                               out_ready_i,
  output logic [clopd_pkg::TotalW-1:0]      best_total_o
);

  // Commands from the sequencer and status back from the datapath.
  clopd_pkg::cmd_t    cmd;
  clopd_pkg::status_t status;

  // The sequencer owns the input handshake and the phase of each span.
  clopd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_coin_i (last_coin_i),
    .in_ready_o  (in_ready_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // The datapath holds both stores, the walk counters and the output item.
  clopd_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .coin_value_i (coin_value_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .best_total_o (best_total_o)
  );

endmodule
`default_nettype wire
